// ===== hdl/mxt_pkg.sv =====
// ----------------------------------------------------------------------------
// mxt_pkg: shared types and constants for the max-XOR trie unit
// Field widths, parameter defaults, walker state encoding and result bundle.
// ----------------------------------------------------------------------------
package mxt_pkg;

	localparam int KEY_W             = 16;   // key_value field width
	localparam int OUT_W             = 16;   // best_xor / running_max width
	localparam int DEF_KEY_BITS      = 16;
	localparam int DEF_NODE_CAPACITY = 4096;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_ALLOC,
		ST_LEAF,
		ST_QSTART,
		ST_QUERY,
		ST_DONE
	} walk_state_t;

	typedef struct packed {
		logic [OUT_W-1:0] best_xor;
		logic [OUT_W-1:0] running_max;
		logic             table_full;
	} res_t;

endpackage

// ===== hdl/mxt_ram.sv =====
// ----------------------------------------------------------------------------
// mxt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mxt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/mxt_cell.sv =====
// ----------------------------------------------------------------------------
// mxt_cell: one bit slice of the key / result shift chain
// Loads a key bit, or takes its lower neighbor's bit on a shift.
// ----------------------------------------------------------------------------
module mxt_cell (
	input  logic clk,
	input  logic load,
	input  logic load_bit,
	input  logic shift,
	input  logic shift_in,
	output logic q
);

	logic bit_q;

	always_ff @(posedge clk) begin
		if (load) begin
			bit_q <= load_bit;
		end else if (shift) begin
			bit_q <= shift_in;
		end
	end

	assign q = bit_q;

endmodule

// ===== hdl/mxt_walk.sv =====
// ----------------------------------------------------------------------------
// mxt_walk: trie walker
// Inserts a key into the node table if it fits, then walks it for the largest XOR.
// Key bits leave the top of a cell chain MSB first; result bits enter below.
// ----------------------------------------------------------------------------
module mxt_walk #(
	parameter int KEY_BITS      = 16,
	parameter int NODE_CAPACITY = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mxt_pkg::KEY_W-1:0]   key_value,
	input  logic                        start_new,
	output logic                        res_valid,
	input  logic                        res_ready,
	output mxt_pkg::res_t               res
);

	import mxt_pkg::*;

	localparam int IW    = $clog2(NODE_CAPACITY);
	localparam int CNT_W = $clog2(NODE_CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int PW    = $clog2(KEY_BITS);

	walk_state_t state_q, state_d;

	logic [2*IW-1:0]     root_kids_q;
	logic [CNT_W-1:0]    used_q;
	logic [OUT_W-1:0]    best_q;
	logic [KEY_BITS-1:0] key_q;
	logic [PW-1:0]       pos_q;
	logic [IW-1:0]       cur_q;
	logic                cur_root_q;
	logic [IW-1:0]       par_q;
	logic                par_root_q;
	logic [2*IW-1:0]     par_kids_q;
	logic                first_q;
	logic                full_q;
	logic                empty_q;

	logic [KEY_BITS-1:0] key_in;
	logic [KEY_BITS-1:0] chain;
	logic [KEY_BITS-1:0] load_bits;
	logic                ch_load;
	logic                ch_shift;
	logic                shift_bit;

	logic [2*IW-1:0]     rdata;
	logic [2*IW-1:0]     cur_kids;
	logic                kbit;
	logic [IW-1:0]       same_kid;
	logic [IW-1:0]       opp_kid;
	logic [IW-1:0]       q_next;
	logic [IW-1:0]       free_idx;
	logic [2*IW-1:0]     alloc_kids;
	logic [SUM_W-1:0]    need_sum;
	logic                fits;
	logic                root_empty;
	logic                accept;

	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [2*IW-1:0]     ram_wdata;
	logic                ram_re;
	logic [IW-1:0]       ram_raddr;

	logic [OUT_W-1:0]    best_ext;
	logic [OUT_W-1:0]    best_now;
	logic [OUT_W-1:0]    run_max;

	// key zero-extended or truncated to KEY_BITS; result zero-extended or cut to OUT_W
	for (genvar i = 0; i < KEY_BITS; i++) begin : g_key
		if (i < KEY_W) begin : g_in
			assign key_in[i] = key_value[i];
		end else begin : g_zero
			assign key_in[i] = 1'b0;
		end
	end

	for (genvar j = 0; j < OUT_W; j++) begin : g_best
		if (j < KEY_BITS) begin : g_in
			assign best_ext[j] = chain[j];
		end else begin : g_zero
			assign best_ext[j] = 1'b0;
		end
	end

	// shift chain: top cell presents the current key bit
	for (genvar i = 0; i < KEY_BITS; i++) begin : g_cell
		logic sin;
		if (i == 0) begin : g_lsb
			assign sin = shift_bit;
		end else begin : g_up
			assign sin = chain[i-1];
		end
		mxt_cell u_cell (
			.clk      (clk),
			.load     (ch_load),
			.load_bit (load_bits[i]),
			.shift    (ch_shift),
			.shift_in (sin),
			.q        (chain[i])
		);
	end

	mxt_ram #(
		.WIDTH (2*IW),
		.DEPTH (NODE_CAPACITY)
	) u_nodes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// datapath selection
	always_comb begin
		cur_kids   = cur_root_q ? root_kids_q : rdata;
		kbit       = chain[KEY_BITS-1];
		same_kid   = kbit ? cur_kids[2*IW-1:IW] : cur_kids[IW-1:0];
		opp_kid    = kbit ? cur_kids[IW-1:0] : cur_kids[2*IW-1:IW];
		q_next     = (opp_kid != '0) ? opp_kid : same_kid;
		free_idx   = used_q[IW-1:0];
		need_sum   = SUM_W'(used_q) + SUM_W'(pos_q) + SUM_W'(1);
		fits       = need_sum <= SUM_W'(NODE_CAPACITY);
		root_empty = (root_kids_q == '0);
		accept     = (state_q == ST_IDLE) && in_valid;
		if (first_q) begin
			alloc_kids = kbit ? {free_idx, par_kids_q[IW-1:0]}
			                  : {par_kids_q[2*IW-1:IW], free_idx};
		end else begin
			alloc_kids = kbit ? {free_idx, IW'(0)} : {IW'(0), free_idx};
		end
		best_now = empty_q ? '0 : best_ext;
		run_max  = (best_now > best_q) ? best_now : best_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_FIND;
			end
			ST_FIND: begin
				if (same_kid == '0) begin
					state_d = fits ? ST_ALLOC : ST_QSTART;
				end else if (pos_q == '0) begin
					state_d = ST_QSTART;
				end
			end
			ST_ALLOC: begin
				if (pos_q == '0) state_d = ST_LEAF;
			end
			ST_LEAF:   state_d = ST_QSTART;
			ST_QSTART: state_d = root_empty ? ST_DONE : ST_QUERY;
			ST_QUERY: begin
				if (pos_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = same_kid;
		ram_we    = 1'b0;
		ram_waddr = par_q;
		ram_wdata = alloc_kids;
		ch_load   = 1'b0;
		load_bits = key_q;
		ch_shift  = 1'b0;
		shift_bit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ch_load   = in_valid;
				load_bits = key_in;
			end
			ST_FIND: begin
				ram_re   = (same_kid != '0);
				ch_shift = (same_kid != '0);
			end
			ST_ALLOC: begin
				ram_we   = !par_root_q;
				ch_shift = 1'b1;
			end
			ST_LEAF: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			ST_QSTART: begin
				ch_load = 1'b1;
			end
			ST_QUERY: begin
				ram_re    = 1'b1;
				ram_raddr = q_next;
				ch_shift  = 1'b1;
				shift_bit = (opp_kid != '0);
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			root_kids_q <= '0;
			used_q      <= CNT_W'(1);
			best_q      <= '0;
		end else begin
			state_q <= state_d;
			if (accept && start_new) begin
				root_kids_q <= '0;
				used_q      <= CNT_W'(1);
				best_q      <= '0;
			end
			if (state_q == ST_ALLOC) begin
				used_q <= used_q + CNT_W'(1);
				if (par_root_q) begin
					if (kbit) begin
						root_kids_q[2*IW-1:IW] <= free_idx;
					end else begin
						root_kids_q[IW-1:0] <= free_idx;
					end
				end
			end
			if ((state_q == ST_DONE) && res_ready) begin
				best_q <= run_max;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					key_q      <= key_in;
					pos_q      <= PW'(KEY_BITS - 1);
					cur_root_q <= 1'b1;
					full_q     <= 1'b0;
					empty_q    <= 1'b0;
				end
			end
			ST_FIND: begin
				if (same_kid == '0) begin
					par_q      <= cur_q;
					par_root_q <= cur_root_q;
					par_kids_q <= cur_kids;
					first_q    <= 1'b1;
					if (!fits) full_q <= 1'b1;
				end else begin
					cur_q      <= same_kid;
					cur_root_q <= 1'b0;
					if (pos_q != '0) pos_q <= pos_q - PW'(1);
				end
			end
			ST_ALLOC: begin
				par_q      <= free_idx;
				par_root_q <= 1'b0;
				first_q    <= 1'b0;
				if (pos_q != '0) pos_q <= pos_q - PW'(1);
			end
			ST_QSTART: begin
				pos_q      <= PW'(KEY_BITS - 1);
				cur_root_q <= 1'b1;
				empty_q    <= root_empty;
			end
			ST_QUERY: begin
				cur_root_q <= 1'b0;
				if (pos_q != '0) pos_q <= pos_q - PW'(1);
			end
			default: begin
				first_q <= first_q;
			end
		endcase
	end

	assign res.best_xor    = best_now;
	assign res.running_max = run_max;
	assign res.table_full  = full_q;

endmodule

// ===== hdl/max_xor_pair_trie_unit.sv =====
// ----------------------------------------------------------------------------
// max_xor_pair_trie_unit: maximum-XOR-pair search over a binary trie
// Inserts each key into a node table and reports the best XOR against the set.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ group: s_tdata carries the key, s_tuser marks
//   the first key of a new set (clears the trie and the running maximum
//   before the key is handled). One response per request leaves on the m_
//   group: best XOR, running maximum and a table-full flag.
//   Each request walks the trie twice through a node memory with registered
//   read data: insert (for a new key, walk down and one node per missing
//   level, plus one leaf write) and query (KEY_BITS levels), plus accept,
//   query start and handoff states. The pace is set by the dependent read
//   chain through the node memory; one request is in flight.
//   A full node table leaves the set unchanged; the query still runs and
//   m_tuser reports the miss.
//   Reset empties the set (root without children) and clears the running
//   maximum; the node memory needs no clearing pass.
//   A stalled receiver holds the response in the output register; the next
//   request is still accepted and worked on, and its response waits in the
//   walker until the output register frees.
// ----------------------------------------------------------------------------
module max_xor_pair_trie_unit #(
	parameter int KEY_BITS      = mxt_pkg::DEF_KEY_BITS,
	parameter int NODE_CAPACITY = mxt_pkg::DEF_NODE_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] key_value
	input  logic        s_tuser,   // [0] start_new
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] best_xor, [31:16] running_max
	output logic        m_tuser    // [0] table_full
);

	import mxt_pkg::*;

	logic res_valid;
	logic res_ready;
	res_t res;
	logic out_valid_q;
	res_t out_res_q;

	// trie walker: insert then query, one request at a time
	mxt_walk #(
		.KEY_BITS      (KEY_BITS),
		.NODE_CAPACITY (NODE_CAPACITY)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.key_value (s_tdata[KEY_W-1:0]),
		.start_new (s_tuser),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: take a new response when empty or draining this cycle
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload: hold while stalled, no reset needed
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_res_q.running_max, out_res_q.best_xor};
	assign m_tuser  = out_res_q.table_full;

	// walker never accepts a request while its response is still pending
	a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !s_tready)
		else $error("request accepted while response pending");

	// a handed-off response shows up on the output next cycle
	a_handoff_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> m_tvalid)
		else $error("handed-off response not presented");

	// running maximum never falls below the reported best XOR
	a_max_bounds_best: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:16] >= m_tdata[15:0]))
		else $error("running maximum below best XOR");

endmodule

// ===== dv/max_xor_pair_trie_checker.sv =====
// ----------------------------------------------------------------------------
// max_xor_pair_trie_checker: response checker for the max-XOR trie unit
// Mirrors the trie in its own node table, predicts each response from the
// accepted requests and compares the responses field by field, in order.
// ----------------------------------------------------------------------------
module max_xor_pair_trie_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] key_value
	input  logic        s_tuser,   // [0] start_new
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [15:0] best_xor, [31:16] running_max
	input  logic        m_tuser,   // [0] table_full
	output int          fail_count,
	output int          backlog
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_BITS = mxt_pkg::DEF_KEY_BITS;
	localparam int NODE_CAP = mxt_pkg::DEF_NODE_CAPACITY;
	localparam int OUT_W    = mxt_pkg::OUT_W;

	// child links per node; 0 means no child (the root is never a child)
	int unsigned      kids [NODE_CAP][2];
	int unsigned      nodes_taken;
	logic [OUT_W-1:0] peak_xor;
	mxt_pkg::res_t    due_results[$];
	int               errs = 0;

	assign fail_count = errs;

	function automatic void empty_set();
		kids[0][0]  = 0;
		kids[0][1]  = 0;
		nodes_taken = 1;
		peak_xor    = '0;
	endfunction

	// nodes a key would add: everything below the first missing link
	function automatic int unsigned missing_nodes(logic [15:0] key);
		int unsigned nd;
		nd = 0;
		for (int p = KEY_BITS - 1; p >= 0; p--) begin
			if (kids[nd][key[p]] == 0)
				return p + 1;
			nd = kids[nd][key[p]];
		end
		return 0;
	endfunction

	function automatic void add_key(logic [15:0] key);
		int unsigned nd;
		int unsigned nx;
		nd = 0;
		for (int p = KEY_BITS - 1; p >= 0; p--) begin
			nx = kids[nd][key[p]];
			if (nx == 0) begin
				nx = nodes_taken;
				nodes_taken++;
				kids[nx][0] = 0;
				kids[nx][1] = 0;
				kids[nd][key[p]] = nx;
			end
			nd = nx;
		end
	endfunction

	// greedy walk: take the branch opposite to the key bit wherever it exists
	function automatic logic [OUT_W-1:0] best_partner_xor(logic [15:0] key);
		int unsigned      nd;
		int unsigned      alt;
		logic [OUT_W-1:0] acc;
		nd  = 0;
		acc = '0;
		if (kids[0][0] == 0 && kids[0][1] == 0)
			return '0;
		for (int p = KEY_BITS - 1; p >= 0; p--) begin
			alt = kids[nd][!key[p]];
			acc = acc << 1;
			if (alt != 0) begin
				acc[0] = 1'b1;
				nd     = alt;
			end else begin
				nd = kids[nd][key[p]];
				if (nd == 0)
					break;
			end
		end
		return acc;
	endfunction

	function automatic mxt_pkg::res_t predict_response(logic [15:0] key, logic fresh);
		mxt_pkg::res_t r;
		if (fresh)
			empty_set();
		r.table_full = (nodes_taken > NODE_CAP) ||
			(missing_nodes(key) > NODE_CAP - nodes_taken);
		if (!r.table_full)
			add_key(key);
		r.best_xor = best_partner_xor(key);
		if (r.best_xor > peak_xor)
			peak_xor = r.best_xor;
		r.running_max = peak_xor;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mxt_pkg::res_t want;
		if (!arst_n) begin
			empty_set();
			due_results.delete();
			backlog <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("response with no request pending: best_xor %0h", m_tdata[15:0]);
					errs++;
				end else begin
					want = due_results.pop_front();
					if (m_tdata[15:0] !== want.best_xor) begin
						$error("best_xor: expected %0h, got %0h", want.best_xor, m_tdata[15:0]);
						errs++;
					end
					if (m_tdata[31:16] !== want.running_max) begin
						$error("running_max: expected %0h, got %0h",
							want.running_max, m_tdata[31:16]);
						errs++;
					end
					if (m_tuser !== want.table_full) begin
						$error("table_full: expected %0b, got %0b", want.table_full, m_tuser);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				due_results.push_back(predict_response(s_tdata, s_tuser));
			backlog <= due_results.size();
		end
	end

endmodule

// ===== dv/tb_max_xor_pair_trie_unit.sv =====
// ----------------------------------------------------------------------------
// tb_max_xor_pair_trie_unit: stimulus and verdict for the max-XOR trie unit
// Sends directed keys, one long set that fills the node table and then random
// sets, with random idle on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_max_xor_pair_trie_unit;

	timeunit 1ns;
	timeprecision 1ps;

	// drain wait: longer than the slowest request, with slack on top
	localparam int DRAIN_CYCLES = 2 * mxt_pkg::DEF_KEY_BITS + 12;
	// ~500 requests, each with its busy time plus sender gaps and
	// receiver stalls; several times the slowest plausible run
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;    // [15:0] key_value
	logic        s_tuser  = 1'b0;  // [0] start_new
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // [15:0] best_xor, [31:16] running_max
	logic        m_tuser;          // [0] table_full

	logic        steady   = 1'b0;  // high: neither side idles
	int          fail_count;
	int          backlog;
	int          cycles   = 0;
	int          stall_left = 0;
	logic [15:0] seen_keys[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	max_xor_pair_trie_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	max_xor_pair_trie_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.backlog    (backlog)
	);

	// Receiver: drop ready in about a third of the cycles, now and then hold
	// it low for a long stall so that finished responses back up in the walker.
	always @(negedge clk) begin
		if (steady) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if ($urandom_range(999) < 2) begin
			stall_left <= $urandom_range(80, 20);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= 33);
		end
	end

	// Watchdog: a hung handshake or a lost response ends up here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_max_xor_pair_trie_unit NOT OK");
			$finish;
		end
	end

	// Present one request and hold it until accepted. Idle first at random:
	// mostly short gaps, sometimes a long one so the next request lands on a
	// different phase of the walk. Valid is only lowered inside a gap, never
	// right after an accept, so back-to-back requests keep it high.
	task automatic send_request(input logic [15:0] key, input logic fresh);
		int gap;
		gap = 0;
		if (!steady) begin
			if ($urandom_range(99) < 4)
				gap = $urandom_range(60, 1);
			else
				while ($urandom_range(99) < 33)
					gap++;
		end
		if (gap > 0) begin
			// drive junk on the idle bus; it must be ignored
			s_tvalid <= 1'b0;
			s_tdata  <= 16'($urandom);
			s_tuser  <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tuser  <= fresh;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		seen_keys.push_back(key);
	endtask

	// {start_new, key_value}: empty set after reset, all-zero and all-one keys,
	// duplicates, MSB split, alternating patterns, and a restart that must drop
	// the running maximum back to what the lone key gives.
	localparam logic [16:0] DIRECTED [20] = '{
		{1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b0, 16'h0000}, {1'b1, 16'h8000},
		{1'b0, 16'h8000}, {1'b0, 16'h7FFF}, {1'b1, 16'h5555}, {1'b0, 16'hAAAA},
		{1'b0, 16'h5554}, {1'b1, 16'h0001}, {1'b0, 16'h0002}, {1'b0, 16'h0003},
		{1'b1, 16'h00FF}, {1'b0, 16'hFF00}, {1'b0, 16'h0F0F}, {1'b0, 16'hF0F0},
		{1'b1, 16'h3333}, {1'b0, 16'hCCCC}, {1'b0, 16'h3333}, {1'b1, 16'h0000}
	};

	initial begin
		logic [15:0] key;
		int          roll;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED[n])
			send_request(DIRECTED[n][15:0], DIRECTED[n][16]);

		// Fill the node table in one set. Mirror the index into the top bits so
		// the keys spread as widely as possible (each new key adds the most
		// nodes), and randomize the bits below. Around key 449 the table runs
		// out of room; the rest of the set comes back full. Every so often
		// resend an earlier key: one already in the set needs no nodes and is never full.
		for (int i = 0; i < 452; i++) begin
			if (i == 150)
				steady <= 1'b1;
			if (i == 250)
				steady <= 1'b0;
			for (int b = 0; b < 16; b++)
				key[15 - b] = i[b];
			key[6:0] = 7'($urandom);
			send_request(key, i == 0);
			if (i % 64 == 63)
				send_request(seen_keys[$urandom_range(seen_keys.size() - 1)], 1'b0);
		end

		// Table now full: stored duplicates still fit, fresh keys do not.
		for (int i = 0; i < 6; i++) begin
			if (i % 2 == 0)
				send_request(seen_keys[$urandom_range(seen_keys.size() - 1)], 1'b0);
			else
				send_request(16'($urandom), 1'b0);
		end

		// Random sets: restart at the first request and then now and then.
		// Mix uniform keys, repeats, one-bit neighbors of earlier keys and the
		// extreme values.
		for (int i = 0; i < 12; i++) begin
			roll = $urandom_range(99);
			if (roll < 50)
				key = 16'($urandom);
			else if (roll < 70)
				key = seen_keys[$urandom_range(seen_keys.size() - 1)];
			else if (roll < 85)
				key = seen_keys[$urandom_range(seen_keys.size() - 1)] ^
					(16'h0001 << $urandom_range(15));
			else
				case ($urandom_range(3))
					0: key = 16'h0000;
					1: key = 16'hFFFF;
					2: key = 16'h8000;
					default: key = 16'h7FFF;
				endcase
			send_request(key, (i == 0) || ($urandom_range(15) == 0));
		end
		s_tvalid <= 1'b0;

		// Drain: wait out every pending response, then watch for strays.
		while (backlog != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb_max_xor_pair_trie_unit OK");
		else
			$display("tb_max_xor_pair_trie_unit NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/mxt_pkg.sv
hdl/mxt_ram.sv
hdl/mxt_cell.sv
hdl/mxt_walk.sv
hdl/max_xor_pair_trie_unit.sv
dv/max_xor_pair_trie_checker.sv
dv/tb_max_xor_pair_trie_unit.sv
